>>> rtl/bdq_pkg.sv
// Shared types, constants and helper functions for the bounded deque queue.
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KEY_W = 32;
  localparam int CMD_W = 3;
  localparam int LIMIT_W = 5;
  localparam int COUNT_OUT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP        = 3'd2,
    CMD_PEEK       = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Access to the entry store for one command.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // Everything about a result except the key read from the store.
  typedef struct packed {
    logic             key_from_store;
    logic             key_all_ones;
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } res_info_t;

  // The limit never exceeds the physical depth.
  function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] limit);
    logic [CNT_W-1:0] result;
    if (32'(limit) > DEPTH) begin
      result = CNT_W'(DEPTH);
    end else begin
      result = CNT_W'(limit);
    end
    return result;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_prev(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] result;
    if (idx == '0) begin
      result = ADDR_W'(DEPTH - 1);
    end else begin
      result = idx - ADDR_W'(1);
    end
    return result;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] result;
    if (32'(idx) + 1 >= DEPTH) begin
      result = '0;
    end else begin
      result = idx + ADDR_W'(1);
    end
    return result;
  endfunction

  // Position one past the last entry; the sum stays below twice the depth.
  function automatic logic [ADDR_W-1:0] tail_pos(input logic [ADDR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
    logic [ADDR_W+CNT_W-1:0] sum;
    logic [ADDR_W-1:0] result;
    sum = (ADDR_W+CNT_W)'(head) + (ADDR_W+CNT_W)'(count);
    if (32'(sum) >= DEPTH) begin
      result = ADDR_W'(32'(sum) - DEPTH);
    end else begin
      result = ADDR_W'(sum);
    end
    return result;
  endfunction

endpackage

>>> rtl/bdq_store.sv
// Entry store: one write port and one read port, registered read data.
module bdq_store (
  input  logic                           clk,
  input  bdq_pkg::store_req_t            req,
  output logic [bdq_pkg::KEY_W-1:0]      rd_data
);

  logic [bdq_pkg::KEY_W-1:0] mem [bdq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds until the next read, so a stalled result keeps its key.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/bdq_ctrl.sv
// Command decode, head and count registers, and the limit register.
module bdq_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [bdq_pkg::CMD_W-1:0]        command,
  input  logic signed [bdq_pkg::KEY_W-1:0] key_in,
  input  logic                             cfg_we,
  input  logic [bdq_pkg::LIMIT_W-1:0]      cfg_data,
  output bdq_pkg::store_req_t              store_req,
  output bdq_pkg::res_info_t               info
);

  logic [bdq_pkg::ADDR_W-1:0]  head;
  logic [bdq_pkg::ADDR_W-1:0]  head_next;
  logic [bdq_pkg::CNT_W-1:0]   count;
  logic [bdq_pkg::CNT_W-1:0]   count_next;
  logic [bdq_pkg::LIMIT_W-1:0] limit;
  logic [bdq_pkg::CNT_W-1:0]   lim_eff;
  logic                        full;
  logic                        is_empty_cmd;

  assign lim_eff = bdq_pkg::eff_limit(limit);
  assign full = (count >= lim_eff);
  assign is_empty_cmd = (count == '0);

  always_comb begin
    head_next = head;
    count_next = count;
    store_req = '0;
    store_req.wdata = key_in;
    store_req.raddr = head;
    store_req.waddr = head;
    info = '0;
    info.status = bdq_pkg::ST_DONE;

    unique case (command)
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          info.status = bdq_pkg::ST_FULL;
        end else begin
          head_next = bdq_pkg::wrap_prev(head);
          count_next = count + bdq_pkg::CNT_W'(1);
          store_req.we = accept;
          store_req.waddr = bdq_pkg::wrap_prev(head);
        end
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          info.status = bdq_pkg::ST_FULL;
        end else begin
          count_next = count + bdq_pkg::CNT_W'(1);
          store_req.we = accept;
          store_req.waddr = bdq_pkg::tail_pos(head, count);
        end
      end
      bdq_pkg::CMD_POP, bdq_pkg::CMD_PEEK: begin
        if (is_empty_cmd) begin
          info.status = bdq_pkg::ST_EMPTY;
          info.key_all_ones = 1'b1;
        end else begin
          info.key_from_store = 1'b1;
          store_req.re = accept;
          if (command == bdq_pkg::CMD_POP) begin
            head_next = bdq_pkg::wrap_next(head);
            count_next = count - bdq_pkg::CNT_W'(1);
          end
        end
      end
      bdq_pkg::CMD_CLEAR: begin
        head_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase

    info.count = count_next;
    info.is_empty = (count_next == '0);
    info.is_full = (count_next >= lim_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else if (accept) begin
      head <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bdq_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

endmodule

>>> rtl/bounded_deque_queue.sv
// Top level of the bounded deque queue: control, entry store and result register.
// A bounded queue of signed 32-bit keys in a 16-entry ring buffer that allows
// insertion at either end. Each command transfer produces exactly one result
// transfer, through the middle stage and then the result register. A command
// is taken whenever cmd_stall is low: head and count update at
// acceptance, and a pop or peek reads the head entry through the registered
// store read, so the throughput is one command per clock while not stalled.
// A stalled result holds back the input once the middle stage is also occupied.
// The limit register may be written at any time the block is idle; cfg_ready
// is always high.
module bounded_deque_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [bdq_pkg::CMD_W-1:0]          command,
  input  logic signed [bdq_pkg::KEY_W-1:0]   key_in,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [bdq_pkg::KEY_W-1:0]   key_out,
  output logic [1:0]                         status,
  output logic [bdq_pkg::COUNT_OUT_W-1:0]    entry_count,
  output logic                               is_empty,
  output logic                               is_full,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdq_pkg::LIMIT_W-1:0]        cfg_data
);

  bdq_pkg::store_req_t       store_req;
  bdq_pkg::res_info_t        info;
  bdq_pkg::res_info_t        p1_info;
  logic                      p1_valid;
  logic                      p1_advance;
  logic                      accept;
  logic [bdq_pkg::KEY_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  // The middle stage waits for the store read; it moves on when the
  // result register is empty or its transfer completes.
  assign p1_advance = p1_valid && (!res_valid || !res_stall);
  assign cmd_stall = p1_valid && !p1_advance;
  assign accept = cmd_valid && !cmd_stall;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .key_in    (key_in),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .store_req (store_req),
    .info      (info)
  );

  bdq_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (p1_advance) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (p1_advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_advance) begin
      if (p1_info.key_from_store) begin
        key_out <= rd_data;
      end else if (p1_info.key_all_ones) begin
        key_out <= '1;
      end else begin
        key_out <= '0;
      end
      status <= p1_info.status;
      entry_count <= bdq_pkg::COUNT_OUT_W'(p1_info.count);
      is_empty <= p1_info.is_empty;
      is_full <= p1_info.is_full;
    end
  end

endmodule
